/* src/assert_macros.svh */
// Assertion macros used by the controller of the voxel octree lookup.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define VXO_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Checks that a trigger is followed on the next clock edge by a condition.
`define VXO_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

/* src/vxo_pkg.sv */
// Package with the payload types, codes and the command and status structs of the voxel octree lookup.
`timescale 1ns / 1ps
`default_nettype none
package vxo_pkg;

    localparam int COORD_W = 32;
    localparam int WORD_W  = 12;
    localparam int MAT_W   = 8;
    localparam int SLOT_W  = 3;

    localparam logic [COORD_W-1:0] SIGN_FLIP = 32'h8000_0000;

    typedef enum logic {
        FUNC_WRITE  = 1'b0,
        FUNC_LOOKUP = 1'b1
    } func_t;

    typedef struct packed {
        func_t                      func;
        logic signed [COORD_W-1:0]  coord_x;
        logic signed [COORD_W-1:0]  coord_y;
        logic signed [COORD_W-1:0]  coord_z;
        logic [WORD_W-1:0]          node_slot;
        logic [SLOT_W-1:0]          child_slot;
        logic [WORD_W-1:0]          child_word;
    } req_t;

    typedef struct packed {
        logic [MAT_W-1:0] material;
        logic             walk_error;
    } rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_en;
        logic write_en;
        logic load_en;
        logic step_root;
        logic step_word;
        logic res_load;
        logic res_err;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic root_bad;
        logic word_is_mat;
        logic word_bad;
        logic last_level;
    } sts_t;

endpackage
`default_nettype wire

/* src/vxo_req_if.sv */
// Request channel interface of the voxel octree lookup.
`timescale 1ns / 1ps
`default_nettype none
interface vxo_req_if
    import vxo_pkg::*;
;
    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* src/vxo_rsp_if.sv */
// Result channel interface of the voxel octree lookup.
`timescale 1ns / 1ps
`default_nettype none
interface vxo_rsp_if
    import vxo_pkg::*;
;
    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* src/vxo_datapath.sv */
// Datapath of the voxel octree lookup: child store, walk registers and result register.
`timescale 1ns / 1ps
`default_nettype none
module vxo_datapath
    import vxo_pkg::*;
#(
    parameter int NODE_COUNT     = 4096,
    parameter int MATERIAL_COUNT = 256,
    parameter int ROOT_NODE      = 256,
    parameter int LEVELS         = 32
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire req_t req_data,
    input  wire cmd_t cmd,
    output sts_t      sts,
    output rsp_t      rsp_data
);

    localparam int NODE_IDX_W  = $clog2(NODE_COUNT);
    localparam int ADDR_W      = NODE_IDX_W + SLOT_W;
    localparam int DEPTH       = NODE_COUNT * 8;
    localparam int HGT_W       = $clog2(LEVELS + 1);
    localparam int COORD_SHIFT = COORD_W - LEVELS;

    localparam logic [ADDR_W-1:0]     CLEAR_LAST = ADDR_W'(DEPTH - 1);
    localparam logic [NODE_IDX_W-1:0] ROOT_IDX   = NODE_IDX_W'(ROOT_NODE);
    localparam logic [HGT_W-1:0]      HGT_INIT   = HGT_W'(LEVELS);
    localparam logic [HGT_W-1:0]      HGT_ONE    = HGT_W'(1);

    logic [WORD_W-1:0] mem [DEPTH];

    logic [WORD_W-1:0]  rd_data_reg;
    logic [ADDR_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [COORD_W-1:0] x_reg, x_next;
    logic [COORD_W-1:0] y_reg, y_next;
    logic [COORD_W-1:0] z_reg, z_next;
    logic [HGT_W-1:0]   hgt_reg, hgt_next;
    logic [MAT_W-1:0]   mat_reg;
    logic               err_reg;

    logic [SLOT_W-1:0]              slot;
    logic [NODE_IDX_W+WORD_W-1:0]   word_ext;
    logic [NODE_IDX_W+WORD_W-1:0]   wr_node_ext;
    logic [NODE_IDX_W-1:0]          word_idx;
    logic [NODE_IDX_W-1:0]          wr_node_idx;
    logic [ADDR_W-1:0]              rd_addr;
    logic [ADDR_W-1:0]              wr_addr;
    logic                           rd_en;
    logic                           wr_en;
    logic [WORD_W-1:0]              wr_data;
    logic                           wr_in_range;

    // The coordinates are kept aligned so that the bit of the current level sits at the top.
    assign slot = {z_reg[COORD_W-1], y_reg[COORD_W-1], x_reg[COORD_W-1]};

    // Node numbers are zero extended before being cut to the index width of the store.
    assign word_ext    = {{NODE_IDX_W{1'b0}}, rd_data_reg};
    assign wr_node_ext = {{NODE_IDX_W{1'b0}}, req_data.node_slot};
    assign word_idx    = word_ext[NODE_IDX_W-1:0];
    assign wr_node_idx = wr_node_ext[NODE_IDX_W-1:0];

    assign rd_en   = cmd.step_root | cmd.step_word;
    assign rd_addr = cmd.step_root ? {ROOT_IDX, slot} : {word_idx, slot};

    assign wr_in_range = (32'(req_data.node_slot) < 32'(NODE_COUNT));
    assign wr_en       = cmd.clear_en | (cmd.write_en & wr_in_range);
    assign wr_addr     = cmd.clear_en ? clr_cnt_reg : {wr_node_idx, req_data.child_slot};
    assign wr_data     = cmd.clear_en ? '0 : req_data.child_word;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        clr_cnt_next = clr_cnt_reg;
        if (cmd.clear_en)
        begin
            clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
        end
    end

    always_comb
    begin
        x_next   = x_reg;
        y_next   = y_reg;
        z_next   = z_reg;
        hgt_next = hgt_reg;
        if (cmd.load_en)
        begin
            x_next   = ($unsigned(req_data.coord_x) ^ SIGN_FLIP) << COORD_SHIFT;
            y_next   = ($unsigned(req_data.coord_y) ^ SIGN_FLIP) << COORD_SHIFT;
            z_next   = ($unsigned(req_data.coord_z) ^ SIGN_FLIP) << COORD_SHIFT;
            hgt_next = HGT_INIT;
        end
        else if (rd_en)
        begin
            x_next = {x_reg[COORD_W-2:0], 1'b0};
            y_next = {y_reg[COORD_W-2:0], 1'b0};
            z_next = {z_reg[COORD_W-2:0], 1'b0};
            if (cmd.step_word)
            begin
                hgt_next = hgt_reg - HGT_ONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
        hgt_reg <= hgt_next;
        if (cmd.res_load)
        begin
            mat_reg <= cmd.res_err ? '0 : rd_data_reg[MAT_W-1:0];
            err_reg <= cmd.res_err;
        end
    end

    // The height register counts the level whose child word is in the read register.
    assign sts.clear_last  = (clr_cnt_reg == CLEAR_LAST);
    assign sts.root_bad    = (32'(ROOT_NODE) >= 32'(NODE_COUNT));
    assign sts.word_is_mat = (32'(rd_data_reg) < 32'(MATERIAL_COUNT));
    assign sts.word_bad    = (32'(rd_data_reg) >= 32'(NODE_COUNT));
    assign sts.last_level  = (hgt_reg == HGT_ONE);

    assign rsp_data.material   = mat_reg;
    assign rsp_data.walk_error = err_reg;

endmodule
`default_nettype wire

/* src/vxo_ctrl.sv */
// Controller state machine of the voxel octree lookup.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module vxo_ctrl
    import vxo_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  req_valid,
    input  wire func_t req_func,
    output logic       req_ready,
    output logic       rsp_valid,
    input  wire logic  rsp_ready,
    input  wire sts_t  sts,
    output cmd_t       cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_WALK
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;
    logic   res_free;
    logic   req_acc;

    // A new result may be loaded once the previous one has left or is leaving.
    assign res_free  = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == ST_IDLE);
    assign req_acc   = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_en = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_acc)
                begin
                    unique case (req_func)
                        FUNC_WRITE:
                        begin
                            cmd.write_en = 1'b1;
                        end
                        FUNC_LOOKUP:
                        begin
                            cmd.load_en = 1'b1;
                            state_next  = ST_START;
                        end
                        default:
                        begin
                            cmd.write_en = 1'b0;
                        end
                    endcase
                end
            end
            ST_START:
            begin
                if (sts.root_bad)
                begin
                    if (res_free)
                    begin
                        cmd.res_load = 1'b1;
                        cmd.res_err  = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.step_root = 1'b1;
                    state_next    = ST_WALK;
                end
            end
            ST_WALK:
            begin
                // A finished walk holds here, with no read, until the result register frees.
                if (sts.word_is_mat || sts.last_level || sts.word_bad)
                begin
                    if (res_free)
                    begin
                        cmd.res_load = 1'b1;
                        cmd.res_err  = !sts.word_is_mat;
                        state_next   = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.step_word = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.res_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    `VXO_ALWAYS(a_store_port_single, $onehot0({cmd.clear_en, cmd.write_en, cmd.step_root, cmd.step_word}), "store port used twice in one cycle")
    `VXO_ALWAYS(a_no_result_overwrite, !cmd.res_load || !rsp_valid_reg || rsp_ready, "pending result overwritten")
    `VXO_NEXT(a_result_shown, cmd.res_load, rsp_valid, "loaded result not offered")
    `VXO_NEXT(a_step_stays_walk, cmd.step_word || cmd.step_root, state_reg == ST_WALK, "read issued outside the walk")

endmodule
`default_nettype wire

/* src/voxel_octree_lookup_core.sv */
// Top level of the voxel octree lookup: controller, datapath and channel wiring.
`timescale 1ns / 1ps
`default_nettype none
// After reset the block sweeps all NODE_COUNT * 8 entries of the child store (32768 at
// the defaults) to zero, one entry a cycle, and takes no request until the sweep ends.
// Requests are then taken one at a time. A write request stores one child word and
// gives no result. A lookup request reads the store once per tree level, one read a
// cycle through its single read port, and its result is loaded into the output
// register when the walk ends; a walk that reaches a material at an upper level ends
// before the last level. A finished walk waits while the previous result has not been
// taken. The next request is taken in the cycle after the result is loaded, while
// that result may still wait to be taken.
module voxel_octree_lookup_core
    import vxo_pkg::*;
#(
    parameter int NODE_COUNT     = 4096,
    parameter int MATERIAL_COUNT = 256,
    parameter int ROOT_NODE      = 256,
    parameter int LEVELS         = 32
) (
    input wire logic  clk,
    input wire logic  rst_n,
    vxo_req_if.sink   req,
    vxo_rsp_if.source rsp
);

    cmd_t cmd;
    sts_t sts;
    logic ctrl_req_ready;
    logic ctrl_rsp_valid;
    rsp_t dp_rsp_data;

    vxo_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_func  (req.data.func),
        .req_ready (ctrl_req_ready),
        .rsp_valid (ctrl_rsp_valid),
        .rsp_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    vxo_datapath #(
        .NODE_COUNT     (NODE_COUNT),
        .MATERIAL_COUNT (MATERIAL_COUNT),
        .ROOT_NODE      (ROOT_NODE),
        .LEVELS         (LEVELS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_data (req.data),
        .cmd      (cmd),
        .sts      (sts),
        .rsp_data (dp_rsp_data)
    );

    assign req.ready = ctrl_req_ready;
    assign rsp.valid = ctrl_rsp_valid;
    assign rsp.data  = dp_rsp_data;

endmodule
`default_nettype wire

/* verif/tb.sv */
// Testbench for the voxel octree lookup core: directed and random requests checked against a mirror of the child store.
`timescale 1ns / 1ps
module tb;
    import vxo_pkg::*;

    localparam int NODE_CNT    = 4096;
    localparam int MAT_CNT     = 256;
    localparam int ROOT        = 256;
    localparam int LEVEL_CNT   = 32;
    localparam int ITEM_TARGET = 1550;
    localparam int HOLD_CYCLES = 400;

    // Mirror of the child store that predicts each lookup and checks the results.
    class octree_mirror;
        logic [WORD_W-1:0] child_words [0:NODE_CNT*8-1];
        rsp_t              expected_voxels [$];
        int unsigned       fail_count;

        function new();
            foreach (child_words[i])
                child_words[i] = '0;
            fail_count = 0;
        endfunction

        function rsp_t lookup_voxel(input req_t r);
            logic [COORD_W-1:0] ox;
            logic [COORD_W-1:0] oy;
            logic [COORD_W-1:0] oz;
            logic [WORD_W-1:0]  word;
            int unsigned        node;
            rsp_t               res;
            ox = r.coord_x ^ SIGN_FLIP;
            oy = r.coord_y ^ SIGN_FLIP;
            oz = r.coord_z ^ SIGN_FLIP;
            node = ROOT;
            res.material = '0;
            res.walk_error = 1'b1;
            for (int h = LEVEL_CNT; h >= 1; h--)
            begin
                if (node >= NODE_CNT)
                    return res;
                word = child_words[node * 8 + {oz[h-1], oy[h-1], ox[h-1]}];
                if (word < MAT_CNT)
                begin
                    res.material = word[MAT_W-1:0];
                    res.walk_error = 1'b0;
                    return res;
                end
                node = 32'(word);
            end
            return res;
        endfunction

        function void note_request(input req_t r);
            if (r.func == FUNC_WRITE)
            begin
                if (r.node_slot < NODE_CNT)
                    child_words[r.node_slot * 8 + r.child_slot] = r.child_word;
            end
            else
                expected_voxels.push_back(lookup_voxel(r));
        endfunction

        function void check_result(input rsp_t got);
            rsp_t want;
            if (expected_voxels.size() == 0)
            begin
                $error("result with no lookup pending: material %0d walk_error %0d",
                       got.material, got.walk_error);
                fail_count++;
                return;
            end
            want = expected_voxels.pop_front();
            if (got.material !== want.material)
            begin
                $error("material: expected %0d, got %0d", want.material, got.material);
                fail_count++;
            end
            if (got.walk_error !== want.walk_error)
            begin
                $error("walk_error: expected %0d, got %0d", want.walk_error, got.walk_error);
                fail_count++;
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    vxo_req_if    req_ch();
    vxo_rsp_if    rsp_ch();
    octree_mirror board = new();
    int           tx_idle_pct = 8;
    int           rx_idle_pct = 83;
    bit           hold_pending = 1'b0;
    int           sent = 0;
    int           next_free = ROOT + 1;

    voxel_octree_lookup_core #(
        .NODE_COUNT     (NODE_CNT),
        .MATERIAL_COUNT (MAT_CNT),
        .ROOT_NODE      (ROOT),
        .LEVELS         (LEVEL_CNT)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("tb NOT OK");
        $finish;
    end

    function automatic req_t mk_write(input int node, input int slot, input int word);
        req_t r;
        r.func       = FUNC_WRITE;
        r.coord_x    = $urandom();
        r.coord_y    = $urandom();
        r.coord_z    = $urandom();
        r.node_slot  = node[WORD_W-1:0];
        r.child_slot = slot[SLOT_W-1:0];
        r.child_word = word[WORD_W-1:0];
        return r;
    endfunction

    function automatic req_t mk_lookup(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                                       input logic [COORD_W-1:0] z);
        req_t r;
        r.func       = FUNC_LOOKUP;
        r.coord_x    = x;
        r.coord_y    = y;
        r.coord_z    = z;
        r.node_slot  = WORD_W'($urandom_range(NODE_CNT - 1));
        r.child_slot = SLOT_W'($urandom_range(7));
        r.child_word = WORD_W'($urandom_range(NODE_CNT - 1));
        return r;
    endfunction

    // Child slot at height h for coordinates already in offset binary.
    function automatic logic [SLOT_W-1:0] slot_at(input logic [COORD_W-1:0] ox,
                                                  input logic [COORD_W-1:0] oy,
                                                  input logic [COORD_W-1:0] oz, input int h);
        return {oz[h-1], oy[h-1], ox[h-1]};
    endfunction

    function automatic int fresh_node();
        int n;
        n = next_free;
        next_free = (next_free == NODE_CNT - 1) ? ROOT + 1 : next_free + 1;
        return n;
    endfunction

    function automatic logic [COORD_W-1:0] maybe_flip(input logic [COORD_W-1:0] v, input int pos);
        if ($urandom_range(1) == 1)
            return v ^ (32'h1 << pos);
        return v;
    endfunction

    task automatic send_req(input req_t r);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        board.note_request(r);
        sent++;
    endtask

    // Sets a voxel the way a tree editor would: reuse the existing branch, then add
    // fresh nodes down to the requested depth. An incomplete path leaves a dangling
    // pointer; an overrun path hangs a node below the last level.
    task automatic grow_path(input logic [COORD_W-1:0] ox, input logic [COORD_W-1:0] oy,
                             input logic [COORD_W-1:0] oz, input int depth,
                             input bit overrun, input bit complete);
        int                node;
        int                lvl;
        int                nxt;
        logic [WORD_W-1:0] word;
        node = ROOT;
        lvl = 0;
        while (lvl < depth - 1)
        begin
            word = board.child_words[node * 8 + slot_at(ox, oy, oz, LEVEL_CNT - lvl)];
            if (word < MAT_CNT)
                break;
            node = 32'(word);
            lvl++;
        end
        while (lvl < depth - 1)
        begin
            nxt = fresh_node();
            send_req(mk_write(node, slot_at(ox, oy, oz, LEVEL_CNT - lvl), nxt));
            node = nxt;
            lvl++;
        end
        if (complete)
            send_req(mk_write(node, slot_at(ox, oy, oz, LEVEL_CNT - lvl),
                              overrun ? $urandom_range(NODE_CNT - 1, MAT_CNT)
                                      : $urandom_range(MAT_CNT - 1)));
    endtask

    initial
    begin : result_sink
        int hold_left;
        hold_left = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
                board.check_result(rsp_ch.data);
            if (hold_pending)
            begin
                hold_left = HOLD_CYCLES;
                hold_pending = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial
    begin : stimulus
        logic [COORD_W-1:0] ox;
        logic [COORD_W-1:0] oy;
        logic [COORD_W-1:0] oz;
        int                 depth;
        int                 pick;
        int                 pos;
        int                 phase_end;
        bit                 overrun;
        bit                 complete;

        rst_n        <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Empty tree at the coordinate extremes.
        send_req(mk_lookup(32'h0, 32'h0, 32'h0));
        send_req(mk_lookup(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
        // Largest material straight under the root.
        send_req(mk_write(ROOT, 7, MAT_CNT - 1));
        send_req(mk_lookup(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_req(mk_lookup(32'h0, 32'h0, 32'h0));
        // A root that points at itself runs past the last level.
        send_req(mk_write(ROOT, 0, ROOT));
        send_req(mk_lookup(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_req(mk_lookup(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        // Low nodes and the highest node number.
        send_req(mk_write(0, 3, 77));
        send_req(mk_write(MAT_CNT - 1, 5, NODE_CNT - 1));
        send_req(mk_write(NODE_CNT - 1, 0, 12));
        send_req(mk_write(ROOT, 1, NODE_CNT - 1));
        send_req(mk_lookup(32'h0, 32'h8000_0000, 32'h8000_0000));
        // Smallest node number, again looping through the root.
        send_req(mk_write(ROOT, 2, MAT_CNT));
        send_req(mk_lookup(32'h8000_0000, 32'h0, 32'h8000_0000));
        send_req(mk_write(ROOT, 0, 0));
        send_req(mk_write(ROOT, 2, 0));
        send_req(mk_lookup(32'h8000_0000, 32'h0, 32'h8000_0000));

        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    tx_idle_pct = 8;
                    rx_idle_pct = 83;
                end
                1:
                begin
                    tx_idle_pct = 83;
                    rx_idle_pct = 8;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                    hold_pending = 1'b1;
                end
            endcase
            phase_end = sent + ITEM_TARGET / 3;
            while (sent < phase_end)
            begin
                pick = $urandom_range(99);
                if (pick < 70)
                begin
                    ox = $urandom();
                    oy = $urandom();
                    oz = $urandom();
                    overrun = ($urandom_range(7) == 0);
                    complete = ($urandom_range(9) != 0);
                    depth = overrun ? LEVEL_CNT : $urandom_range(LEVEL_CNT, 1);
                    grow_path(ox, oy, oz, depth, overrun, complete);
                    // The voxel itself and neighbors that split off at some level of the path.
                    repeat ($urandom_range(4, 1))
                    begin
                        pos = $urandom_range(LEVEL_CNT - 1, LEVEL_CNT - depth);
                        if ($urandom_range(2) == 0)
                            send_req(mk_lookup(ox ^ SIGN_FLIP, oy ^ SIGN_FLIP, oz ^ SIGN_FLIP));
                        else
                            send_req(mk_lookup(maybe_flip(ox, pos) ^ SIGN_FLIP,
                                               maybe_flip(oy, pos) ^ SIGN_FLIP,
                                               maybe_flip(oz, pos) ^ SIGN_FLIP));
                    end
                end
                else if (pick < 85)
                    send_req(mk_lookup($urandom(), $urandom(), $urandom()));
                else
                    send_req(mk_write($urandom_range(NODE_CNT - 1), $urandom_range(7),
                                      $urandom_range(NODE_CNT - 1)));
            end
        end
        req_ch.valid <= 1'b0;

        while (board.expected_voxels.size() != 0)
            @(posedge clk);
        repeat (2 * LEVEL_CNT) @(posedge clk);

        if (board.fail_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end
endmodule
